// ===== design/bfmc_pkg.sv =====
// Package for the chained-hash Bloom filter: opcodes, hash constants, the
// datapath command type and the controller/datapath command and status structs.
// No dependencies.
package bfmc_pkg;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_TEST = 2'd1;
	localparam logic [1:0] OP_TADD = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2  = 32'h1b873593;
	localparam logic [31:0] MM_ADD = 32'he6546b64;
	localparam logic [31:0] MM_F1  = 32'h85ebca6b;
	localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

	localparam logic [4:0] NUM_HASHES_RST = 5'd3;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_PASS,
		CMD_RINIT,
		CMD_K1,
		CMD_K2,
		CMD_K3,
		CMD_F1,
		CMD_F2,
		CMD_F3,
		CMD_MOD,
		CMD_RD,
		CMD_WR,
		CMD_CHK,
		CMD_CLR
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       n_zero;
		logic       no_chunks;
		logic       chunk_last;
		logic       mod_last;
		logic       round_last;
		logic       clr_last;
		logic       all_set;
		logic       hit;
	} stat_t;

endpackage

// ===== design/bfmc_datapath.sv =====
// Datapath of the Bloom filter: key registers, the MurmurHash3 round unit with
// one multiplier step per cycle, a reciprocal modulo unit and the filter memory.
// Depends on bfmc_pkg.
module bfmc_datapath
	import bfmc_pkg::*;
#(
	parameter int FILTER_SIZE   = 65536,
	parameter int MAX_KEY_BYTES = 8,
	localparam int IDXW         = $clog2(FILTER_SIZE)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	output stat_t       st,
	output logic        present
);

	// The quotient is floor(h * RECIP / 2^(32 + IDXW)), exact for every 32-bit h.
	localparam logic [63:0]     RECIP_W = ((64'd1 << (32 + IDXW)) + 64'(FILTER_SIZE) - 64'd1)
		/ 64'(FILTER_SIZE);
	localparam logic [32:0]     RECIP  = RECIP_W[32:0];
	localparam logic [31:0]     FSZ    = 32'(FILTER_SIZE);
	localparam logic [IDXW-1:0] LASTIX = IDXW'(FILTER_SIZE - 1);
	localparam logic [3:0]      MAXLEN = 4'(MAX_KEY_BYTES);

	logic [4:0]      nh_q;
	logic [1:0]      op_q;
	logic [63:0]     key_q;
	logic [3:0]      len_q;
	logic [31:0]     h_q;
	logic [31:0]     k_q;
	logic            blk_q;
	logic [4:0]      round_q;
	logic [IDXW-1:0] r_q;
	logic [31:0]     q_q;
	logic [31:0]     qn_q;
	logic [1:0]      cnt_q;
	logic            all_q;
	logic            rd_q;
	logic [IDXW-1:0] clr_q;
	logic            filt_q [FILTER_SIZE];

	logic [1:0]      nblocks;
	logic [1:0]      total;
	logic            is_block;
	logic [31:0]     word_raw;
	logic [31:0]     word;
	logic [31:0]     k_rot;
	logic [31:0]     hx;
	logic [31:0]     hx_rot;
	logic [31:0]     t1;
	logic [31:0]     t2;
	logic [64:0]     prod;
	logic [31:0]     modv;
	logic [5:0]      round_nx;
	logic            we;
	logic [IDXW-1:0] wa;
	logic [IDXW-1:0] ra;

	always_comb begin
		nblocks  = len_q[3:2];
		total    = nblocks + {1'b0, |len_q[1:0]};
		is_block = {1'b0, blk_q} < nblocks;
		word_raw = blk_q ? key_q[63:32] : key_q[31:0];
		case (len_q[1:0])
			2'd1: word = {24'd0, word_raw[7:0]};
			2'd2: word = {16'd0, word_raw[15:0]};
			2'd3: word = {8'd0, word_raw[23:0]};
			default: word = word_raw;
		endcase
		if (is_block) begin
			word = word_raw;
		end
		k_rot    = {k_q[16:0], k_q[31:17]};
		hx       = h_q ^ k_q;
		hx_rot   = {hx[18:0], hx[31:19]};
		t1       = h_q ^ {28'd0, len_q};
		t1       = t1 ^ (t1 >> 16);
		t2       = h_q ^ (h_q >> 13);
		prod     = 65'(h_q) * 65'(RECIP);
		modv     = h_q - qn_q;
		round_nx = {1'b0, round_q} + 6'd1;
		we       = (ctl.cmd == CMD_WR) || (ctl.cmd == CMD_CLR);
		ra       = r_q;
		wa       = (ctl.cmd == CMD_CLR) ? clr_q : ra;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			filt_q[wa] <= (ctl.cmd == CMD_WR);
		end
		if (ctl.cmd == CMD_RD) begin
			rd_q <= filt_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nh_q  <= NUM_HASHES_RST;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				nh_q <= cfg_data;
			end
			if (ctl.cmd == CMD_CLR) begin
				clr_q <= clr_q + IDXW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				op_q  <= opcode;
				key_q <= key_bytes;
				len_q <= (key_length > MAXLEN) ? MAXLEN : key_length;
				all_q <= 1'b1;
			end
			CMD_PASS: begin
				h_q     <= '0;
				round_q <= '0;
			end
			CMD_RINIT: blk_q <= 1'b0;
			CMD_K1: k_q <= word * MM_C1;
			CMD_K2: k_q <= k_rot * MM_C2;
			CMD_K3: begin
				h_q   <= is_block ? ((hx_rot << 2) + hx_rot + MM_ADD) : hx;
				blk_q <= ~blk_q;
			end
			CMD_F1: h_q <= t1 * MM_F1;
			CMD_F2: h_q <= t2 * MM_F2;
			CMD_F3: begin
				h_q   <= h_q ^ (h_q >> 16);
				cnt_q <= '0;
			end
			CMD_MOD: begin
				case (cnt_q)
					2'd0: q_q <= 32'(prod >> (32 + IDXW));
					2'd1: qn_q <= q_q * FSZ;
					default: r_q <= modv[IDXW-1:0];
				endcase
				cnt_q <= cnt_q + 2'd1;
			end
			CMD_WR: round_q <= round_nx[4:0];
			CMD_CHK: begin
				round_q <= round_nx[4:0];
				if (!rd_q) begin
					all_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.op         = op_q;
		st.n_zero     = (nh_q == 5'd0);
		st.no_chunks  = (total == 2'd0);
		st.chunk_last = ({1'b0, blk_q} + 2'd1) == total;
		st.mod_last   = (cnt_q == 2'd2);
		st.round_last = (round_nx == {1'b0, nh_q});
		st.clr_last   = (clr_q == LASTIX);
		st.all_set    = all_q;
		st.hit        = rd_q;
		present       = all_q && ((op_q == OP_TEST) || (op_q == OP_TADD));
	end

endmodule

// ===== design/bfmc_ctrl.sv =====
// Controller of the Bloom filter: one-hot state machine that clears the
// filter after reset and sequences the hash rounds and filter accesses.
// Depends on bfmc_pkg.
module bfmc_ctrl
	import bfmc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output ctl_t  ctl,
	output logic  busy,
	output logic  done
);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_DISP  = 15'b000000000000100,
		S_PASS2 = 15'b000000000001000,
		S_RINIT = 15'b000000000010000,
		S_K1    = 15'b000000000100000,
		S_K2    = 15'b000000001000000,
		S_K3    = 15'b000000010000000,
		S_F1    = 15'b000000100000000,
		S_F2    = 15'b000001000000000,
		S_F3    = 15'b000010000000000,
		S_MOD   = 15'b000100000000000,
		S_ACC   = 15'b001000000000000,
		S_CHK   = 15'b010000000000000,
		S_DONE  = 15'b100000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   wr_q;
	logic   wr_d;

	always_comb begin
		state_d = state_q;
		wr_d    = wr_q;
		ctl.cmd = CMD_NOP;
		case (state_q)
			S_CLEAR: begin
				ctl.cmd = CMD_CLR;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.cmd = CMD_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if ((st.op == OP_NONE) || st.n_zero) begin
					state_d = S_DONE;
				end else begin
					ctl.cmd = CMD_PASS;
					wr_d    = (st.op == OP_ADD);
					state_d = S_RINIT;
				end
			end
			S_PASS2: begin
				ctl.cmd = CMD_PASS;
				wr_d    = 1'b1;
				state_d = S_RINIT;
			end
			S_RINIT: begin
				ctl.cmd = CMD_RINIT;
				state_d = st.no_chunks ? S_F1 : S_K1;
			end
			S_K1: begin
				ctl.cmd = CMD_K1;
				state_d = S_K2;
			end
			S_K2: begin
				ctl.cmd = CMD_K2;
				state_d = S_K3;
			end
			S_K3: begin
				ctl.cmd = CMD_K3;
				state_d = st.chunk_last ? S_F1 : S_K1;
			end
			S_F1: begin
				ctl.cmd = CMD_F1;
				state_d = S_F2;
			end
			S_F2: begin
				ctl.cmd = CMD_F2;
				state_d = S_F3;
			end
			S_F3: begin
				ctl.cmd = CMD_F3;
				state_d = S_MOD;
			end
			S_MOD: begin
				ctl.cmd = CMD_MOD;
				if (st.mod_last) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				if (wr_q) begin
					ctl.cmd = CMD_WR;
					state_d = st.round_last ? S_DONE : S_RINIT;
				end else begin
					ctl.cmd = CMD_RD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				ctl.cmd = CMD_CHK;
				if (!st.round_last) begin
					state_d = S_RINIT;
				end else if ((st.op == OP_TADD) && !(st.all_set && st.hit)) begin
					state_d = S_PASS2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			wr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_q    <= wr_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("Controller state is not one-hot.");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("Result strobe lasted more than one cycle.");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted beat did not make the block busy.");
	a_write_no_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> !wr_q)
		else $error("Test check ran during a write pass.");

endmodule

// ===== design/bloom_filter_murmur_chain_top.sv =====
// Top level of the chained-MurmurHash3 Bloom filter.
// Instantiates bfmc_ctrl and bfmc_datapath; depends on bfmc_pkg.
//
// After reset the block clears its filter memory one bit per cycle, which
// keeps busy high until it is all clear. An item is taken when start is high
// and busy is low; its result appears with done high for exactly one cycle,
// and the receiver cannot hold it back, so it must take present in that cycle.
// Each hash round runs over the 32-bit chunks of the key (0 to 2) in steps:
// one to start the round, three multiplier steps per chunk, three for the
// final mix, three for the reduction modulo FILTER_SIZE by reciprocal
// multiplication and one for the memory access in a write pass or two in a
// test pass. An item runs num_hashes rounds, and a test-and-add of an absent
// key runs the rounds twice, once to test and once to set the bits, with the
// S_PASS2 state between the passes.
module bloom_filter_murmur_chain_top
	import bfmc_pkg::*;
#(
	parameter int FILTER_SIZE   = 65536,
	parameter int MAX_KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	output logic        done,
	output logic        present,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	ctl_t  ctl;
	stat_t st;

	assign cfg_ready = 1'b1;

	bfmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	bfmc_datapath #(
		.FILTER_SIZE   (FILTER_SIZE),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.opcode     (opcode),
		.key_bytes  (key_bytes),
		.key_length (key_length),
		.st         (st),
		.present    (present)
	);

endmodule
